### src/cartesian_to_spherical_binary_angle_unit_defines.svh
// Assertion macros shared by the checker of the conversion unit.
`ifndef CARTESIAN_TO_SPHERICAL_BINARY_ANGLE_UNIT_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_BINARY_ANGLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define C2S_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define C2S_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/c2s_pkg.sv
// Types, constants and helpers of the cartesian to spherical conversion unit.
package c2s_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int RADIUS_WIDTH = 25;

  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int MAG_W    = COORD_WIDTH;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int SQ_W     = 2 * MAG_W + 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int NORM_MSB = 28;
  localparam int NORM_W   = NORM_MSB + 1;
  localparam int SHIFT_W  = 5;

  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_LAST  = CORDIC_STEPS - 1;
  localparam int CORDIC_IN_W  = 31;
  localparam int CORDIC_W     = 34;
  localparam int ZACC_W       = 32;
  localparam int ANG_W        = 31;
  localparam int LEN_W        = 32;
  localparam int PROD_W       = 64;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  localparam int A_W   = 33;
  localparam int NUM_W = 49;

  localparam int THETA_POST = 4;
  localparam int PHI_POST   = 2;
  localparam int RAD_DLY    = 2 * CORDIC_LAT + THETA_POST + PHI_POST - ROOT_W;

  localparam logic [31:0]              INV_GAIN     = 32'h9B74_EDA8;
  localparam logic [PROD_W-1:0]        ROUND_HALF   = 64'h0000_0000_8000_0000;
  localparam logic [ANG_W-1:0]         TURN_QUARTER = 31'h4000_0000;
  localparam logic signed [ZACC_W-1:0] ZACC_QUARTER = 32'sh4000_0000;
  localparam logic signed [A_W-1:0]    TURN_HALF    = 33'sh0_8000_0000;
  localparam logic signed [NUM_W-1:0]  NUM_BIAS     = 49'sh0_0000_8000_0000;
  localparam logic signed [NUM_W-1:0]  NUM_TRUNC    = 49'sh0_0000_FFFF_FFFF;
  localparam logic [ANGLE_WIDTH-1:0]   ROT_CONST    = 16'h3FFF;

  // atan(2^-i) in units of 2^-32 turn
  localparam int unsigned ATAN_TAB [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic                          rotate_polar;
  } in_t;

  typedef struct packed {
    logic [RADIUS_WIDTH-1:0] radius;
    logic [ANGLE_WIDTH-1:0]  polar_angle;
    logic [ANGLE_WIDTH-1:0]  azimuth_angle;
  } out_t;

  // Sideband that rides along the angle path.
  typedef struct packed {
    logic [NORM_W-1:0]      uy;
    logic                   neg_x;
    logic                   neg_y;
    logic                   neg_z;
    logic                   rotate;
    logic [ANGLE_WIDTH-1:0] theta;
  } tag_t;

  // Left shift that brings the top set bit of m to NORM_MSB.
  function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        s = SHIFT_W'(NORM_MSB - i);
      end
    end
    return s;
  endfunction

endpackage

### src/c2s_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module c2s_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [c2s_pkg::SQ_W-1:0]   sq_i,
  output logic [c2s_pkg::ROOT_W-1:0] root_o
);

  logic [c2s_pkg::REM_W-1:0]  rem_q  [c2s_pkg::ROOT_W];
  logic [c2s_pkg::ROOT_W-1:0] root_q [c2s_pkg::ROOT_W];
  logic [c2s_pkg::SQ_W-1:0]   sq_q   [c2s_pkg::ROOT_W];

  for (genvar k = 0; k < c2s_pkg::ROOT_W; k++) begin : g_stage
    logic [c2s_pkg::REM_W-1:0]  rem_s, rem_d;
    logic [c2s_pkg::ROOT_W-1:0] root_s, root_d;
    logic [c2s_pkg::SQ_W-1:0]   sq_s;
    logic [c2s_pkg::REM_W+1:0]  rem_t, trial;

    if (k == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign sq_s   = sq_i;
    end else begin : g_next
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign sq_s   = sq_q[k-1];
    end

    always_comb begin
      rem_t = {rem_s, sq_s[c2s_pkg::SQ_W-1-2*k -: 2]};
      trial = {1'b0, root_s, 2'b01};
      if (rem_t >= trial) begin
        rem_d  = c2s_pkg::REM_W'(rem_t - trial);
        root_d = {root_s[c2s_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = c2s_pkg::REM_W'(rem_t);
        root_d = {root_s[c2s_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        sq_q[k]   <= sq_s;
      end
    end
  end

  assign root_o = root_q[c2s_pkg::ROOT_W-1];

endmodule

### src/c2s_cordic.sv
// Pipelined first-quadrant CORDIC vectoring: angle and gain-corrected length.
module c2s_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [c2s_pkg::CORDIC_IN_W-1:0] x_i,
  input  logic [c2s_pkg::CORDIC_IN_W-1:0] y_i,
  input  c2s_pkg::tag_t                   tag_i,
  output logic                            valid_o,
  output logic [c2s_pkg::ANG_W-1:0]       ang_o,
  output logic [c2s_pkg::LEN_W-1:0]       len_o,
  output c2s_pkg::tag_t                   tag_o
);

  logic                                 valid_q    [c2s_pkg::CORDIC_STEPS];
  logic signed [c2s_pkg::CORDIC_W-1:0]  cx_q       [c2s_pkg::CORDIC_STEPS];
  logic signed [c2s_pkg::CORDIC_W-1:0]  cy_q       [c2s_pkg::CORDIC_STEPS];
  logic signed [c2s_pkg::ZACC_W-1:0]    z_q        [c2s_pkg::CORDIC_STEPS];
  logic                                 spec_q     [c2s_pkg::CORDIC_STEPS];
  logic                                 spec_qtr_q [c2s_pkg::CORDIC_STEPS];
  logic [c2s_pkg::CORDIC_IN_W-1:0]      spec_len_q [c2s_pkg::CORDIC_STEPS];
  c2s_pkg::tag_t                        tag_q      [c2s_pkg::CORDIC_STEPS];

  for (genvar i = 0; i < c2s_pkg::CORDIC_STEPS; i++) begin : g_step
    logic signed [c2s_pkg::CORDIC_W-1:0] cx_s, cy_s, cx_d, cy_d;
    logic signed [c2s_pkg::ZACC_W-1:0]   z_s, z_d;
    logic                                v_s, sp_s, spq_s;
    logic [c2s_pkg::CORDIC_IN_W-1:0]     spl_s;
    c2s_pkg::tag_t                       tag_s;

    if (i == 0) begin : g_first
      // An operand of zero gives an exact axis result: flag it here.
      assign cx_s  = {{(c2s_pkg::CORDIC_W-c2s_pkg::CORDIC_IN_W){1'b0}}, x_i};
      assign cy_s  = {{(c2s_pkg::CORDIC_W-c2s_pkg::CORDIC_IN_W){1'b0}}, y_i};
      assign z_s   = '0;
      assign v_s   = valid_i;
      assign sp_s  = (y_i == '0) || (x_i == '0);
      assign spq_s = (y_i != '0);
      assign spl_s = (y_i == '0) ? x_i : y_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign cx_s  = cx_q[i-1];
      assign cy_s  = cy_q[i-1];
      assign z_s   = z_q[i-1];
      assign v_s   = valid_q[i-1];
      assign sp_s  = spec_q[i-1];
      assign spq_s = spec_qtr_q[i-1];
      assign spl_s = spec_len_q[i-1];
      assign tag_s = tag_q[i-1];
    end

    always_comb begin
      if (!cy_s[c2s_pkg::CORDIC_W-1]) begin
        cx_d = cx_s + (cy_s >>> i);
        cy_d = cy_s - (cx_s >>> i);
        z_d  = z_s + $signed(c2s_pkg::ATAN_TAB[i][c2s_pkg::ZACC_W-1:0]);
      end else begin
        cx_d = cx_s - (cy_s >>> i);
        cy_d = cy_s + (cx_s >>> i);
        z_d  = z_s - $signed(c2s_pkg::ATAN_TAB[i][c2s_pkg::ZACC_W-1:0]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i]       <= cx_d;
        cy_q[i]       <= cy_d;
        z_q[i]        <= z_d;
        spec_q[i]     <= sp_s;
        spec_qtr_q[i] <= spq_s;
        spec_len_q[i] <= spl_s;
        tag_q[i]      <= tag_s;
      end
    end
  end

  // Gain correction multiply and angle clamp.
  logic                            valid_m_q;
  logic [c2s_pkg::PROD_W-1:0]      prod_d, prod_q;
  logic [c2s_pkg::ANG_W-1:0]       zc_d, zc_q;
  logic                            spec_m_q, spec_qtr_m_q;
  logic [c2s_pkg::CORDIC_IN_W-1:0] spec_len_m_q;
  c2s_pkg::tag_t                   tag_m_q;
  logic signed [c2s_pkg::ZACC_W-1:0] z_last;

  assign z_last = z_q[c2s_pkg::CORDIC_LAST];
  assign prod_d = cx_q[c2s_pkg::CORDIC_LAST][31:0] * c2s_pkg::INV_GAIN;

  always_comb begin
    if (z_last[c2s_pkg::ZACC_W-1]) begin
      zc_d = '0;
    end else if (z_last > c2s_pkg::ZACC_QUARTER) begin
      zc_d = c2s_pkg::TURN_QUARTER;
    end else begin
      zc_d = z_last[c2s_pkg::ANG_W-1:0];
    end
  end

  // Round the length and pick the exact axis result where flagged.
  logic                        valid_o_q;
  logic [c2s_pkg::PROD_W-1:0]  rnd_sum;
  logic [c2s_pkg::ANG_W-1:0]   ang_d, ang_q;
  logic [c2s_pkg::LEN_W-1:0]   len_d, len_q;
  c2s_pkg::tag_t               tag_o_q;

  assign rnd_sum = prod_q + c2s_pkg::ROUND_HALF;

  always_comb begin
    if (spec_m_q) begin
      len_d = {{(c2s_pkg::LEN_W-c2s_pkg::CORDIC_IN_W){1'b0}}, spec_len_m_q};
      ang_d = spec_qtr_m_q ? c2s_pkg::TURN_QUARTER : '0;
    end else begin
      len_d = rnd_sum[c2s_pkg::PROD_W-1 -: c2s_pkg::LEN_W];
      ang_d = zc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else if (en_i) begin
      valid_m_q <= valid_q[c2s_pkg::CORDIC_LAST];
      valid_o_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q       <= prod_d;
      zc_q         <= zc_d;
      spec_m_q     <= spec_q[c2s_pkg::CORDIC_LAST];
      spec_qtr_m_q <= spec_qtr_q[c2s_pkg::CORDIC_LAST];
      spec_len_m_q <= spec_len_q[c2s_pkg::CORDIC_LAST];
      tag_m_q      <= tag_q[c2s_pkg::CORDIC_LAST];
      ang_q        <= ang_d;
      len_q        <= len_d;
      tag_o_q      <= tag_m_q;
    end
  end

  assign valid_o = valid_o_q;
  assign ang_o   = ang_q;
  assign len_o   = len_q;
  assign tag_o   = tag_o_q;

endmodule

### src/cartesian_to_spherical_binary_angle_unit.sv
// Top level of the cartesian to spherical conversion unit with binary-angle output.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to unit   | in_valid_i / in_stall_o   | in_data_i  (c2s_pkg::in_t)
//  out     | from unit | out_valid_o / out_stall_i | out_data_o (c2s_pkg::out_t)
//
//  One transfer per cycle on each side, unless a stalled result holds the pipeline.
//  The latency is set by two chained 33-stage CORDIC pipelines (azimuth first,
//  then polar angle on the horizontal length the first one produces).
//  Reset clears every valid bit; data registers are not reset.
//  A stalled result holds the whole pipeline in place, so nothing is dropped.
module cartesian_to_spherical_binary_angle_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  c2s_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output c2s_pkg::out_t out_data_o
);

  // Advance every stage unless a finished result waits on a stalled sink.
  logic adv;
  logic out_valid_q;
  c2s_pkg::out_t out_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------
  // Stage 1: difference vector d = b - a, exact in one extra bit.
  // ---------------------------------------------------------------------
  localparam int CW = c2s_pkg::COORD_WIDTH;

  logic                              v1_q;
  logic signed [c2s_pkg::DIFF_W-1:0] dx1_q, dy1_q, dz1_q;
  logic                              rot1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q  <= {in_data_i.b_x[CW-1], in_data_i.b_x} - {in_data_i.a_x[CW-1], in_data_i.a_x};
      dy1_q  <= {in_data_i.b_y[CW-1], in_data_i.b_y} - {in_data_i.a_y[CW-1], in_data_i.a_y};
      dz1_q  <= {in_data_i.b_z[CW-1], in_data_i.b_z} - {in_data_i.a_z[CW-1], in_data_i.a_z};
      rot1_q <= in_data_i.rotate_polar;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: magnitudes and signs.
  // ---------------------------------------------------------------------
  logic                             v2_q;
  logic [c2s_pkg::MAG_W-1:0]        ux2_q, uy2_q, uz2_q;
  logic                             nx2_q, ny2_q, nz2_q, rot2_q;
  logic signed [c2s_pkg::DIFF_W-1:0] ax_d, ay_d, az_d;

  assign ax_d = dx1_q[c2s_pkg::DIFF_W-1] ? -dx1_q : dx1_q;
  assign ay_d = dy1_q[c2s_pkg::DIFF_W-1] ? -dy1_q : dy1_q;
  assign az_d = dz1_q[c2s_pkg::DIFF_W-1] ? -dz1_q : dz1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux2_q  <= ax_d[c2s_pkg::MAG_W-1:0];
      uy2_q  <= ay_d[c2s_pkg::MAG_W-1:0];
      uz2_q  <= az_d[c2s_pkg::MAG_W-1:0];
      nx2_q  <= dx1_q[c2s_pkg::DIFF_W-1];
      ny2_q  <= dy1_q[c2s_pkg::DIFF_W-1];
      nz2_q  <= dz1_q[c2s_pkg::DIFF_W-1];
      rot2_q <= rot1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: largest magnitude and the three squares.
  // ---------------------------------------------------------------------
  logic                      v3_q;
  logic [c2s_pkg::MAG_W-1:0] ux3_q, uy3_q, uz3_q, m3_q, mxy_d, m_d;
  logic [c2s_pkg::SQR_W-1:0] sqx3_q, sqy3_q, sqz3_q;
  logic                      nx3_q, ny3_q, nz3_q, rot3_q;

  assign mxy_d = (uy2_q > ux2_q) ? uy2_q : ux2_q;
  assign m_d   = (uz2_q > mxy_d) ? uz2_q : mxy_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      uz3_q  <= uz2_q;
      m3_q   <= m_d;
      sqx3_q <= ux2_q * ux2_q;
      sqy3_q <= uy2_q * uy2_q;
      sqz3_q <= uz2_q * uz2_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      nz3_q  <= nz2_q;
      rot3_q <= rot2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sum of squares and normalizing shift amount.
  // ---------------------------------------------------------------------
  logic                        v4_q;
  logic [c2s_pkg::MAG_W-1:0]   ux4_q, uy4_q, uz4_q;
  logic [c2s_pkg::SQ_W-1:0]    sum4_q;
  logic [c2s_pkg::SHIFT_W-1:0] sh4_q;
  logic                        nx4_q, ny4_q, nz4_q, rot4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux4_q  <= ux3_q;
      uy4_q  <= uy3_q;
      uz4_q  <= uz3_q;
      sum4_q <= {2'b00, sqx3_q} + {2'b00, sqy3_q} + {2'b00, sqz3_q};
      sh4_q  <= c2s_pkg::norm_shift(m3_q);
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      nz4_q  <= nz3_q;
      rot4_q <= rot3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: shift all magnitudes together so the largest sits at bit 28.
  // ---------------------------------------------------------------------
  localparam int PADN = c2s_pkg::NORM_W - c2s_pkg::MAG_W;

  logic                       v5_q;
  logic [c2s_pkg::NORM_W-1:0] ux5_q, uy5_q, uz5_q;
  logic [c2s_pkg::SQ_W-1:0]   sum5_q;
  logic                       nx5_q, ny5_q, nz5_q, rot5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux5_q  <= {{PADN{1'b0}}, ux4_q} << sh4_q;
      uy5_q  <= {{PADN{1'b0}}, uy4_q} << sh4_q;
      uz5_q  <= {{PADN{1'b0}}, uz4_q} << sh4_q;
      sum5_q <= sum4_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      nz5_q  <= nz4_q;
      rot5_q <= rot4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Radius: pipelined square root, then delay to meet the angle path.
  // ---------------------------------------------------------------------
  logic [c2s_pkg::ROOT_W-1:0] root;
  logic [c2s_pkg::ROOT_W-1:0] rad_q [c2s_pkg::RAD_DLY];

  c2s_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sq_i   (sum5_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q[0] <= root;
      for (int k = 1; k < c2s_pkg::RAD_DLY; k++) begin
        rad_q[k] <= rad_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Azimuth CORDIC: atan2(|dx|, |dz|), length gives horizontal distance.
  // ---------------------------------------------------------------------
  localparam int PADC = c2s_pkg::CORDIC_IN_W - c2s_pkg::NORM_W;

  c2s_pkg::tag_t              th_tag_in, th_tag;
  logic                       th_valid;
  logic [c2s_pkg::ANG_W-1:0]  th_ang;
  logic [c2s_pkg::LEN_W-1:0]  th_len;

  always_comb begin
    th_tag_in        = '0;
    th_tag_in.uy     = uy5_q;
    th_tag_in.neg_x  = nx5_q;
    th_tag_in.neg_y  = ny5_q;
    th_tag_in.neg_z  = nz5_q;
    th_tag_in.rotate = rot5_q;
  end

  c2s_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .x_i     ({{PADC{1'b0}}, uz5_q}),
    .y_i     ({{PADC{1'b0}}, ux5_q}),
    .tag_i   (th_tag_in),
    .valid_o (th_valid),
    .ang_o   (th_ang),
    .len_o   (th_len),
    .tag_o   (th_tag)
  );

  // ---------------------------------------------------------------------
  // Azimuth unfold and conversion to a binary angle, four stages.
  // ---------------------------------------------------------------------
  logic                              t1_v_q, t2_v_q, t3_v_q, t4_v_q;
  logic signed [c2s_pkg::A_W-1:0]    t1_a_q, t2_a_q, th_ext;
  logic signed [c2s_pkg::NUM_W-1:0]  t3_num_q, t2_ext;
  logic [c2s_pkg::CORDIC_IN_W-1:0]   t1_h_q, t2_h_q, t3_h_q, t4_h_q;
  c2s_pkg::tag_t                     t1_tag_q, t2_tag_q, t3_tag_q, t4_tag_q, t4_tag_d;
  logic signed [c2s_pkg::NUM_W-1:0]  t4_sum;

  assign th_ext = {{(c2s_pkg::A_W-c2s_pkg::ANG_W){1'b0}}, th_ang};
  assign t2_ext = {{(c2s_pkg::NUM_W-c2s_pkg::A_W){t2_a_q[c2s_pkg::A_W-1]}}, t2_a_q};
  // Truncate toward zero: bias negative numerators before the shift.
  assign t4_sum = t3_num_q + (t3_num_q[c2s_pkg::NUM_W-1] ? c2s_pkg::NUM_TRUNC : '0);

  // Drop the finished azimuth into the sideband.
  always_comb begin
    t4_tag_d       = t3_tag_q;
    t4_tag_d.theta = t4_sum[32 +: c2s_pkg::ANGLE_WIDTH];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_a_q   <= th_tag.neg_z ? (c2s_pkg::TURN_HALF - th_ext) : th_ext;
      t1_h_q   <= th_len[c2s_pkg::CORDIC_IN_W-1:0];
      t1_tag_q <= th_tag;
      t2_a_q   <= t1_tag_q.neg_x ? -t1_a_q : t1_a_q;
      t2_h_q   <= t1_h_q;
      t2_tag_q <= t1_tag_q;
      t3_num_q <= (t2_ext <<< c2s_pkg::ANGLE_WIDTH) - t2_ext + c2s_pkg::NUM_BIAS;
      t3_h_q   <= t2_h_q;
      t3_tag_q <= t2_tag_q;
      t4_h_q   <= t3_h_q;
      t4_tag_q <= t4_tag_d;
    end
  end

  // ---------------------------------------------------------------------
  // Polar CORDIC: atan2(horizontal distance, |dy|).
  // ---------------------------------------------------------------------
  c2s_pkg::tag_t             ph_tag;
  logic                      ph_valid;
  logic [c2s_pkg::ANG_W-1:0] ph_ang;
  logic [c2s_pkg::LEN_W-1:0] ph_len;

  c2s_cordic u_cordic_phi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (t4_v_q),
    .x_i     ({{PADC{1'b0}}, t4_tag_q.uy}),
    .y_i     (t4_h_q),
    .tag_i   (t4_tag_q),
    .valid_o (ph_valid),
    .ang_o   (ph_ang),
    .len_o   (ph_len),
    .tag_o   (ph_tag)
  );

  // ---------------------------------------------------------------------
  // Polar unfold, conversion, then the output register with rotation.
  // ---------------------------------------------------------------------
  logic                              p1_v_q, p2_v_q;
  logic signed [c2s_pkg::A_W-1:0]    p1_a_q, ph_ext;
  logic signed [c2s_pkg::NUM_W-1:0]  p1_ext, p2_num;
  logic [c2s_pkg::ANGLE_WIDTH-1:0]   p2_phi_q;
  c2s_pkg::tag_t                     p1_tag_q, p2_tag_q;
  logic [c2s_pkg::ANGLE_WIDTH-1:0]   phi_fin;
  logic                              len_unused;

  assign ph_ext = {{(c2s_pkg::A_W-c2s_pkg::ANG_W){1'b0}}, ph_ang};
  assign p1_ext = {{(c2s_pkg::NUM_W-c2s_pkg::A_W){p1_a_q[c2s_pkg::A_W-1]}}, p1_a_q};
  assign p2_num = (p1_ext <<< c2s_pkg::ANGLE_WIDTH) - p1_ext + c2s_pkg::NUM_BIAS;
  assign phi_fin = p2_tag_q.rotate ? (c2s_pkg::ROT_CONST - p2_phi_q) : p2_phi_q;
  // Length out of the polar CORDIC is not part of the result.
  assign len_unused = ^ph_len;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_a_q   <= ph_tag.neg_y ? (c2s_pkg::TURN_HALF - ph_ext) : ph_ext;
      p1_tag_q <= ph_tag;
      p2_phi_q <= p2_num[32 +: c2s_pkg::ANGLE_WIDTH];
      p2_tag_q <= p1_tag_q;
      out_q.radius        <= rad_q[c2s_pkg::RAD_DLY-1];
      out_q.polar_angle   <= phi_fin;
      out_q.azimuth_angle <= p2_tag_q.theta;
    end
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      t3_v_q      <= 1'b0;
      t4_v_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      t1_v_q      <= th_valid;
      t2_v_q      <= t1_v_q;
      t3_v_q      <= t2_v_q;
      t4_v_q      <= t3_v_q;
      p1_v_q      <= ph_valid;
      p2_v_q      <= p1_v_q;
      out_valid_q <= p2_v_q & (len_unused | ~len_unused);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/c2s_checker.sv
// Port-level checker for the conversion unit, bound to the top level.
`include "cartesian_to_spherical_binary_angle_unit_defines.svh"

module c2s_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input c2s_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input c2s_pkg::out_t out_data_o
);

  logic in_seen;
  assign in_seen = in_valid_i | (^in_data_i);

  // Backpressure only comes from a held result.
  `C2S_ASSERT_IMP(a_stall_src, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held result")
  // A taken result frees the pipeline for a new transfer.
  `C2S_ASSERT_IMP(a_take_frees, out_valid_o && !out_stall_i, !in_stall_o, "input stalled while result taken")
  // A stalled result holds.
  `C2S_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  // Input side never sees a stall without a pending output.
  `C2S_ASSERT_IMP(a_in_free, in_seen && !out_valid_o, !in_stall_o, "input stalled with empty output")

endmodule

bind cartesian_to_spherical_binary_angle_unit c2s_checker u_c2s_checker (.*);

### tb/tb.sv
// Testbench of the cartesian to spherical conversion unit with binary-angle output.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_ITEMS  = 1150;
  localparam int LIMIT      = 400000;
  localparam int DRAIN_WAIT = 200;

  localparam logic signed [23:0] C_MAX  = 24'sh7F_FFFF;
  localparam logic signed [23:0] C_MIN  = -24'sh80_0000;
  localparam longint            QTURN   = 64'sd1073741824;
  localparam longint            HTURN   = 64'sd2147483648;
  localparam longint unsigned   RAD_TOP = 64'd33554431;
  localparam longint unsigned   KGAIN   = 64'h9B74EDA8;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  c2s_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  c2s_pkg::out_t  out_data_o;

  c2s_pkg::in_t  pending_points[$];
  c2s_pkg::out_t expected_spherical[$];
  int   mismatch_count;
  int   cycle_count;
  int   in_gap;
  int   out_gap;
  bit   stim_done;

  cartesian_to_spherical_binary_angle_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Arithmetic shift that rounds toward minus infinity.
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // First-quadrant CORDIC vectoring; angle in 2^-32 turn, length via len.
  function automatic longint quadrant_angle(input longint unsigned xin,
                                            input longint unsigned yin,
                                            output longint unsigned len);
    longint cx;
    longint cy;
    longint z;
    longint nx;
    cx = xin;
    cy = yin;
    z  = 0;
    if (yin == 0) begin
      len = xin;
      return 0;
    end
    if (xin == 0) begin
      len = yin;
      return QTURN;
    end
    for (int i = 0; i < c2s_pkg::CORDIC_STEPS; i++) begin
      if (cy >= 0) begin
        nx = cx + floor_shift(cy, i);
        cy = cy - floor_shift(cx, i);
        z += longint'(c2s_pkg::ATAN_TAB[i]);
      end else begin
        nx = cx - floor_shift(cy, i);
        cy = cy + floor_shift(cx, i);
        z -= longint'(c2s_pkg::ATAN_TAB[i]);
      end
      cx = nx;
    end
    len = (unsigned'(cx) * KGAIN + (64'd1 << 31)) >> 32;
    if (z < 0) z = 0;
    if (z > QTURN) z = QTURN;
    return z;
  endfunction

  function automatic logic [15:0] turns_to_bam(input longint a);
    longint num;
    longint q;
    num = a * 65535 + HTURN;
    if (num >= 0) q = num >>> 32;
    else q = -((-num) >>> 32);
    return q[15:0];
  endfunction

  function automatic c2s_pkg::out_t convert_point(input c2s_pkg::in_t p);
    longint dx;
    longint dy;
    longint dz;
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned uz;
    longint unsigned m;
    longint unsigned h;
    longint unsigned rad;
    longint a;
    logic [15:0] phi;
    logic [15:0] theta;
    c2s_pkg::out_t r;
    dx = longint'(p.b_x) - longint'(p.a_x);
    dy = longint'(p.b_y) - longint'(p.a_y);
    dz = longint'(p.b_z) - longint'(p.a_z);
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    uz = dz < 0 ? -dz : dz;
    m = ux;
    if (uy > m) m = uy;
    if (uz > m) m = uz;
    phi = '0;
    theta = '0;
    h = 0;
    if (m >= (64'd1 << 25)) rad = RAD_TOP;
    else begin
      rad = root_floor(ux * ux + uy * uy + uz * uz);
      if (rad > RAD_TOP) rad = RAD_TOP;
    end
    if (m != 0) begin
      while (m < (64'd1 << 28)) begin
        m <<= 1; ux <<= 1; uy <<= 1; uz <<= 1;
      end
      while (m >= (64'd1 << 29)) begin
        m >>= 1; ux >>= 1; uy >>= 1; uz >>= 1;
      end
      if (dx != 0 || dz != 0) begin
        a = quadrant_angle(uz, ux, h);
        if (dz < 0) a = HTURN - a;
        if (dx < 0) a = -a;
        theta = turns_to_bam(a);
      end
      a = quadrant_angle(uy, h, m);
      if (dy < 0) a = HTURN - a;
      phi = turns_to_bam(a);
    end
    if (p.rotate_polar) phi = c2s_pkg::ROT_CONST - phi;
    r.radius        = rad[24:0];
    r.polar_angle   = phi;
    r.azimuth_angle = theta;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, sometimes none for a while.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(5))
      0: return C_MAX;
      1: return C_MIN;
      2: return 24'(signed'($urandom_range(2000)) - 1000);
      3: return 24'($urandom);
      default: return 24'(signed'($urandom_range(65535)) - 32768);
    endcase
  endfunction

  task automatic push_point(input logic signed [23:0] ax, ay, az, bx, by, bz,
                            input logic rot);
    c2s_pkg::in_t p;
    p.a_x = ax; p.a_y = ay; p.a_z = az;
    p.b_x = bx; p.b_y = by; p.b_z = bz;
    p.rotate_polar = rot;
    pending_points.push_back(p);
  endtask

  initial begin
    c2s_pkg::in_t p;
    rst_ni = 1'b0;
    // Directed: zero vector, axes, extremes, saturation, rotation.
    push_point(0, 0, 0, 0, 0, 0, 0);
    push_point(0, 0, 0, 0, 0, 0, 1);
    push_point(0, 0, 0, 0, 256, 0, 0);
    push_point(0, 0, 0, 0, -256, 0, 1);
    push_point(0, 0, 0, 256, 0, 0, 0);
    push_point(0, 0, 0, -256, 0, 0, 0);
    push_point(0, 0, 0, 0, 0, 256, 0);
    push_point(0, 0, 0, 0, 0, -256, 1);
    push_point(0, 0, 0, 1, 1, 1, 0);
    push_point(0, 0, 0, -1, -1, -1, 1);
    push_point(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0);
    push_point(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1);
    push_point(0, 0, 0, C_MAX, C_MAX, C_MAX, 0);
    push_point(0, 0, 0, C_MIN, C_MIN, C_MIN, 1);
    push_point(C_MIN, 0, 0, C_MAX, 0, 0, 0);
    push_point(0, C_MAX, 0, 0, C_MIN, 0, 0);
    push_point(12345, -777, 42, 12345, -777, 42, 1);
    push_point(0, 0, 0, -5, 0, -5, 0);
    push_point(0, 0, 0, 5, 3, -5, 1);
    push_point(0, 0, 0, 24'sh3FFFFF, 0, 24'sh3FFFFF, 0);
    for (int n = 0; n < NUM_ITEMS; n++) begin
      p = c2s_pkg::in_t'($bits(c2s_pkg::in_t)'({$urandom, $urandom, $urandom,
                                                  $urandom, $urandom}));
      if ($urandom_range(3) != 0) begin
        p.a_x = pick_coord(); p.a_y = pick_coord(); p.a_z = pick_coord();
        p.b_x = pick_coord(); p.b_y = pick_coord(); p.b_z = pick_coord();
        if ($urandom_range(4) == 0) {p.a_x, p.a_y, p.a_z} = '0;
        if ($urandom_range(9) == 0) p.b_x = p.a_x;
        if ($urandom_range(9) == 0) p.b_z = p.a_z;
        if ($urandom_range(9) == 0) p.b_y = p.a_y;
      end
      pending_points.push_back(p);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: advance to the next point once the current transfer completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
      stim_done  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_spherical.push_back(convert_point(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0 || pending_points.size() == 0) begin
          in_valid_i <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
          if (pending_points.size() == 0) stim_done <= 1'b1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_points.pop_front();
          in_gap     <= pick_gap();
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      out_gap        <= 0;
      mismatch_count <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_spherical.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result r=%0d p=%0d t=%0d", out_data_o.radius,
                     out_data_o.polar_angle, out_data_o.azimuth_angle);
          mismatch_count <= mismatch_count + 1;
        end else begin
          c2s_pkg::out_t e;
          e = expected_spherical.pop_front();
          if (e !== out_data_o) begin
            if (mismatch_count < 10)
              $display("mismatch: exp r=%0d p=%0d t=%0d, got r=%0d p=%0d t=%0d",
                       e.radius, e.polar_angle, e.azimuth_angle, out_data_o.radius,
                       out_data_o.polar_angle, out_data_o.azimuth_angle);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      // Stall pattern is independent of valid.
      if (out_gap > 0) begin
        out_stall_i <= 1'b1;
        out_gap     <= out_gap - 1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap     <= ($urandom_range(2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    cycle_count = 0;
    while (!(stim_done && !in_valid_i && expected_spherical.size() == 0)
           && cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
    end else begin
      repeat (DRAIN_WAIT) @(posedge clk_i);
      if (mismatch_count == 0 && expected_spherical.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

endmodule
